// ----- hdl/quadratic_bspline_point_eval_assert.svh -----
// Assertion macros for the spline evaluator.
`ifndef QUADRATIC_BSPLINE_POINT_EVAL_ASSERT_SVH
`define QUADRATIC_BSPLINE_POINT_EVAL_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define QBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define QBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/qbspe_pkg.sv -----
package qbspe_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int WBITS      = FRAC_BITS + 1;
  localparam int RATIO_W    = WBITS + 1;
  localparam int SCALE      = 1 << WBITS;
  localparam int ONE_T      = 1 << FRAC_BITS;
  localparam int T_W        = 17;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int IO_W       = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 7;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 32;

  localparam logic [CNT_W-1:0] POINT_COUNT_RST = 7'd3;
  localparam logic             BLEND_RST       = 1'b0;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_COUNT  = 8'd0,
    REG_BLEND_ENABLE = 8'd1
  } cfg_reg_t;

endpackage

// ----- hdl/quadratic_bspline_point_eval.sv -----
// Channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------------
// in_      | start & !busy        | operation, point_index, point_x/y/z, param_t
// out_     | out_valid strobe     | curve_x, curve_y, curve_z
// cfg_     | cfg_valid & cfg_ready| cfg_index, cfg_data
//
// One beat a cycle on the input, sustained while busy is low. An evaluate beat
// passes through eight register stages (span search, point read, two smoothstep
// multiplies, weights, two product steps, sum and round) to its out_valid strobe.
// A write beat below the point count lands in the point stores at its accept edge.
// Synchronous active-low reset clears valid bits and loads config defaults; busy
// is high only during reset. The receiver cannot stall, so nothing upstream waits.
module quadratic_bspline_point_eval #(
  parameter int MAX_POINTS = qbspe_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = qbspe_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_operation,
  input  logic        [qbspe_pkg::IDX_W-1:0]     in_point_index,
  input  logic signed [qbspe_pkg::IO_W-1:0]      in_point_x,
  input  logic signed [qbspe_pkg::IO_W-1:0]      in_point_y,
  input  logic signed [qbspe_pkg::IO_W-1:0]      in_point_z,
  input  logic        [qbspe_pkg::T_W-1:0]       in_param_t,
  output logic                                   out_valid,
  output logic signed [qbspe_pkg::IO_W-1:0]      out_curve_x,
  output logic signed [qbspe_pkg::IO_W-1:0]      out_curve_y,
  output logic signed [qbspe_pkg::IO_W-1:0]      out_curve_z,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [qbspe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [qbspe_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NCAP  = (MAX_POINTS < 127) ? MAX_POINTS : 127;
  localparam int CW    = COORD_BITS;
  localparam int RW    = qbspe_pkg::RATIO_W;
  localparam int SH    = 2 * qbspe_pkg::WBITS;
  localparam int WT_W  = SH + 1;                 // weights reach 1.0 = 2^SH
  localparam int LO_W  = qbspe_pkg::WBITS;
  localparam int HI_W  = WT_W - LO_W;
  localparam int PW    = CW + WT_W + 1;
  localparam int SW    = PW + 2;
  localparam int LAT   = 8;
  localparam logic [RW-1:0]   SCALE_R = RW'(qbspe_pkg::SCALE);
  localparam logic [WT_W:0]   WSUM    = (WT_W+1)'(1) << SH;

  // ---------------- configuration ----------------
  logic [qbspe_pkg::CNT_W-1:0] point_count_r;
  logic                        blend_r;
  logic                        busy_r;

  assign cfg_ready = 1'b1;
  assign busy      = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= qbspe_pkg::POINT_COUNT_RST;
      blend_r       <= qbspe_pkg::BLEND_RST;
      busy_r        <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          qbspe_pkg::REG_POINT_COUNT:  point_count_r <= cfg_data;
          qbspe_pkg::REG_BLEND_ENABLE: blend_r       <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // effective point count n, clamped to [3, min(MAX_POINTS, 127)]
  logic [qbspe_pkg::CNT_W-1:0] n_eff, nm2, nm3;
  always_comb begin
    if (point_count_r < 7'd3)              n_eff = 7'd3;
    else if (point_count_r > 7'(NCAP))     n_eff = 7'(NCAP);
    else                                   n_eff = point_count_r;
  end
  assign nm2 = n_eff - 7'd2;
  assign nm3 = n_eff - 7'd3;

  // ---------------- accept / write ----------------
  logic            acc;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [3*CW-1:0] wr_word;

  assign acc     = start && !busy;
  assign wr_en   = acc && (in_operation == qbspe_pkg::OP_WRITE)
                   && ({1'b0, in_point_index} < n_eff);
  assign wr_addr = AW'({{AW{1'b0}}, in_point_index});
  assign wr_word = {CW'(in_point_z), CW'(in_point_y), CW'(in_point_x)};

  // stage 1: scaled parameter u = t * (n-2)
  logic [qbspe_pkg::T_W-1:0] t_sat;
  logic [23:0]               u1_r;
  logic                      v1_r;

  assign t_sat = (in_param_t > 17'(qbspe_pkg::ONE_T)) ? 17'(qbspe_pkg::ONE_T)
                                                      : in_param_t;

  always_ff @(posedge clk) begin
    u1_r <= 24'(t_sat) * 24'(nm2);
  end

  // stage 2: span index, knot ratios, point reads
  logic [7:0]                  idx_raw;
  logic [qbspe_pkg::CNT_W-1:0] idx;
  logic [23:0]                 f_full;
  logic [16:0]                 f;
  logic [RW-1:0]               rat [3];
  logic [AW-1:0]               rd_addr [3];

  always_comb begin
    idx_raw = u1_r[23:16];
    idx     = (idx_raw > {1'b0, nm3}) ? nm3 : idx_raw[6:0];
    f_full  = u1_r - 24'({idx, 16'b0});
    f       = f_full[16:0];
    rat[0]  = {f, 1'b0};
    rat[1]  = (idx == 7'd0) ? {f, 1'b0} : RW'(f) + RW'(qbspe_pkg::ONE_T);
    rat[2]  = (idx == nm3) ? {f, 1'b0} : RW'(f);
    for (int k = 0; k < 3; k++) begin
      rd_addr[k] = AW'({{AW{1'b0}}, 8'({1'b0, idx}) + 8'(k)});
    end
  end

  logic                        v2_r;
  logic [RW-1:0]               r2_r [3];
  logic [qbspe_pkg::CNT_W-1:0] idx2_r;
  logic [3*CW-1:0]             d2_r [3];

  // three copies of the point store, one per span tap
  for (genvar gk = 0; gk < 3; gk++) begin : g_store
    logic [3*CW-1:0] mem [MAX_POINTS];
    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[wr_addr] <= wr_word;
      end
      d2_r[gk] <= mem[rd_addr[gk]];
    end
  end

  always_ff @(posedge clk) begin
    r2_r   <= rat;
    idx2_r <= idx;
  end

  // stage 3: w^2 rounded
  logic          v3_r;
  logic [RW-1:0] w2_nxt [3];
  logic [RW-1:0] w2_3_r [3];
  logic [RW-1:0] r3_r [3];
  logic [3*CW-1:0] d3_r [3];

  always_comb begin
    logic [2*RW:0] sq;
    for (int k = 0; k < 3; k++) begin
      sq        = (2*RW+1)'(r2_r[k]) * (2*RW+1)'(r2_r[k]);
      sq        = sq + (2*RW+1)'(qbspe_pkg::ONE_T);
      w2_nxt[k] = RW'(sq >> qbspe_pkg::WBITS);
    end
  end

  always_ff @(posedge clk) begin
    w2_3_r <= w2_nxt;
    r3_r   <= r2_r;
    d3_r   <= d2_r;
  end

  // stage 4: smoothstep w2*(3-2w), or the plain ratio
  logic            v4_r;
  logic [RW-1:0]   r4_nxt [3];
  logic [RW-1:0]   r4_r [3];
  logic [3*CW-1:0] d4_r [3];

  always_comb begin
    logic [RW:0]     m;
    logic [2*RW+1:0] pr;
    for (int k = 0; k < 3; k++) begin
      m  = (RW+1)'(3 * qbspe_pkg::SCALE) - {r3_r[k], 1'b0};
      pr = (2*RW+2)'(w2_3_r[k]) * (2*RW+2)'(m);
      pr = pr + (2*RW+2)'(qbspe_pkg::ONE_T);
      r4_nxt[k] = blend_r ? RW'(pr >> qbspe_pkg::WBITS) : r3_r[k];
    end
  end

  always_ff @(posedge clk) begin
    r4_r <= r4_nxt;
    d4_r <= d3_r;
  end

  // stage 5: basis weights
  logic            v5_r;
  logic [WT_W-1:0] wt_nxt [3];
  logic [WT_W-1:0] wt5_r [3];
  logic [3*CW-1:0] d5_r [3];

  always_comb begin
    logic [RW-1:0] oa, ob, oc;
    oa = SCALE_R - r4_r[0];
    ob = SCALE_R - r4_r[1];
    oc = SCALE_R - r4_r[2];
    wt_nxt[0] = WT_W'(WT_W'(oa) * WT_W'(ob));
    wt_nxt[1] = WT_W'(WT_W'(oa) * WT_W'(r4_r[1]) + WT_W'(r4_r[0]) * WT_W'(oc));
    wt_nxt[2] = WT_W'(WT_W'(r4_r[0]) * WT_W'(r4_r[2]));
  end

  always_ff @(posedge clk) begin
    wt5_r <= wt_nxt;
    d5_r  <= d4_r;
  end

  // stage 6: partial products, weight split into low and high halves
  logic                     v6_r;
  logic signed [LO_W+CW:0]  pl_nxt [3][3];
  logic signed [HI_W+CW:0]  ph_nxt [3][3];
  logic signed [LO_W+CW:0]  pl6_r [3][3];
  logic signed [HI_W+CW:0]  ph6_r [3][3];

  always_comb begin
    logic signed [CW-1:0] co;
    for (int k = 0; k < 3; k++) begin
      for (int a = 0; a < 3; a++) begin
        co = signed'(d5_r[k][a*CW +: CW]);
        pl_nxt[k][a] = signed'({1'b0, wt5_r[k][LO_W-1:0]}) * co;
        ph_nxt[k][a] = signed'({1'b0, wt5_r[k][WT_W-1:LO_W]}) * co;
      end
    end
  end

  always_ff @(posedge clk) begin
    pl6_r <= pl_nxt;
    ph6_r <= ph_nxt;
  end

  // stage 7: full products
  logic                 v7_r;
  logic signed [PW-1:0] pr_nxt [3][3];
  logic signed [PW-1:0] pr7_r [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int a = 0; a < 3; a++) begin
        pr_nxt[k][a] = (PW'(ph6_r[k][a]) <<< LO_W) + PW'(pl6_r[k][a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    pr7_r <= pr_nxt;
  end

  // stage 8: sum of three taps, round half up, shift down
  logic signed [qbspe_pkg::IO_W-1:0] res_nxt [3];
  logic                              out_valid_r;
  logic signed [qbspe_pkg::IO_W-1:0] res_r [3];

  always_comb begin
    logic signed [SW-1:0] s;
    for (int a = 0; a < 3; a++) begin
      s = SW'(pr7_r[0][a]) + SW'(pr7_r[1][a]) + SW'(pr7_r[2][a])
          + (SW'(1) <<< (SH - 1));
      s = s >>> SH;
      res_nxt[a] = qbspe_pkg::IO_W'(s);
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= acc && (in_operation == qbspe_pkg::OP_EVAL);
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      out_valid_r <= v7_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_curve_x = res_r[0];
  assign out_curve_y = res_r[1];
  assign out_curve_z = res_r[2];

  // ---------------- checks ----------------
`include "quadratic_bspline_point_eval_assert.svh"

  `QBS_ASSERT_NOW(a_out_origin, out_valid, $past(start && !busy && (in_operation == qbspe_pkg::OP_EVAL), LAT), "result without matching evaluate beat")
  `QBS_ASSERT_NOW(a_span_range, v2_r, (8'(idx2_r) + 8'd2) < 8'({1'b0, n_eff}), "span reads past point count")
  `QBS_ASSERT_NOW(a_ratio_range, v4_r, (r4_r[0] <= SCALE_R) && (r4_r[1] <= SCALE_R) && (r4_r[2] <= SCALE_R), "knot ratio above one")
  `QBS_ASSERT_NOW(a_weight_sum, v5_r, ((WT_W+1)'(wt5_r[0]) + (WT_W+1)'(wt5_r[1]) + (WT_W+1)'(wt5_r[2])) == WSUM, "basis weights do not sum to one")
  `QBS_ASSERT_NEXT(a_valid_step, v6_r, v7_r, "valid lost in product stage")

endmodule

// ----- tb/quadratic_bspline_point_eval_checker.sv -----
`timescale 1ns / 1ps

module quadratic_bspline_point_eval_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic                                   busy,
  input  logic                                   in_operation,
  input  logic [qbspe_pkg::IDX_W-1:0]            in_point_index,
  input  logic [qbspe_pkg::IO_W-1:0]             in_point_x,
  input  logic [qbspe_pkg::IO_W-1:0]             in_point_y,
  input  logic [qbspe_pkg::IO_W-1:0]             in_point_z,
  input  logic [qbspe_pkg::T_W-1:0]              in_param_t,
  input  logic                                   out_valid,
  input  logic [qbspe_pkg::IO_W-1:0]             out_curve_x,
  input  logic [qbspe_pkg::IO_W-1:0]             out_curve_y,
  input  logic [qbspe_pkg::IO_W-1:0]             out_curve_z,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  logic [qbspe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [qbspe_pkg::CFG_DATA_W-1:0]       cfg_data,
  output int                                     mismatches,
  output int                                     points_owed,
  output int                                     points_checked
);

  typedef struct packed {
    logic [qbspe_pkg::IO_W-1:0] x;
    logic [qbspe_pkg::IO_W-1:0] y;
    logic [qbspe_pkg::IO_W-1:0] z;
  } curve_pt_t;

  localparam longint unsigned UNIT = 64'd1 << qbspe_pkg::WBITS;

  logic [qbspe_pkg::IO_W-1:0] ctrl_x [qbspe_pkg::MAX_POINTS_DEF];
  logic [qbspe_pkg::IO_W-1:0] ctrl_y [qbspe_pkg::MAX_POINTS_DEF];
  logic [qbspe_pkg::IO_W-1:0] ctrl_z [qbspe_pkg::MAX_POINTS_DEF];
  logic [qbspe_pkg::CNT_W-1:0] n_cfg;
  logic                        blend_cfg;
  curve_pt_t                   owed_q [$];

  function automatic longint unsigned smoothstep(longint unsigned w);
    longint unsigned sq;
    sq = (w * w + UNIT / 2) >> qbspe_pkg::WBITS;
    return (sq * (3 * UNIT - 2 * w) + UNIT / 2) >> qbspe_pkg::WBITS;
  endfunction

  // exact weighted sum of three coordinates, round half up
  function automatic logic [qbspe_pkg::IO_W-1:0] mix3(
    logic [qbspe_pkg::IO_W-1:0] p0, logic [qbspe_pkg::IO_W-1:0] p1,
    logic [qbspe_pkg::IO_W-1:0] p2, longint unsigned w0,
    longint unsigned w1, longint unsigned w2);
    logic signed [95:0] acc;
    acc = $signed({32'd0, w0}) * 96'($signed(p0))
        + $signed({32'd0, w1}) * 96'($signed(p1))
        + $signed({32'd0, w2}) * 96'($signed(p2));
    acc = acc + (96'sd1 <<< (2 * qbspe_pkg::WBITS - 1));
    return acc[2*qbspe_pkg::WBITS +: qbspe_pkg::IO_W];
  endfunction

  function automatic curve_pt_t eval_curve(logic [qbspe_pkg::T_W-1:0] t_in);
    longint unsigned n, t, u, span, f, a, b, c, w0, w1, w2;
    curve_pt_t pt;
    n = (n_cfg < 3) ? 3 : (n_cfg > qbspe_pkg::MAX_POINTS_DEF) ? qbspe_pkg::MAX_POINTS_DEF
                                                               : n_cfg;
    t = (t_in > qbspe_pkg::ONE_T) ? qbspe_pkg::ONE_T : t_in;
    u = t * (n - 2);
    span = u >> qbspe_pkg::FRAC_BITS;
    if (span > n - 3) span = n - 3;
    f = u - (span << qbspe_pkg::FRAC_BITS);
    a = 2 * f;
    b = (span == 0) ? 2 * f : f + qbspe_pkg::ONE_T;
    c = (span == n - 3) ? 2 * f : f;
    if (blend_cfg) begin
      a = smoothstep(a);
      b = smoothstep(b);
      c = smoothstep(c);
    end
    w0 = (UNIT - a) * (UNIT - b);
    w1 = (UNIT - a) * b + a * (UNIT - c);
    w2 = a * c;
    pt.x = mix3(ctrl_x[span], ctrl_x[span+1], ctrl_x[span+2], w0, w1, w2);
    pt.y = mix3(ctrl_y[span], ctrl_y[span+1], ctrl_y[span+2], w0, w1, w2);
    pt.z = mix3(ctrl_z[span], ctrl_z[span+1], ctrl_z[span+2], w0, w1, w2);
    return pt;
  endfunction

  assign points_owed = owed_q.size();

  always @(posedge clk) begin
    curve_pt_t want;
    int n_eff;
    if (!rst_n) begin
      n_cfg          <= qbspe_pkg::POINT_COUNT_RST;
      blend_cfg      <= qbspe_pkg::BLEND_RST;
      mismatches     <= 0;
      points_checked <= 0;
      owed_q.delete();
    end else begin
      if (out_valid) begin
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected curve point x=%h y=%h z=%h", $time,
                   out_curve_x, out_curve_y, out_curve_z);
          mismatches <= mismatches + 1;
        end else begin
          want = owed_q.pop_front();
          points_checked <= points_checked + 1;
          if ({out_curve_x, out_curve_y, out_curve_z} !== want) begin
            $display("%0t: curve point mismatch: expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                     $time, want.x, want.y, want.z, out_curve_x, out_curve_y, out_curve_z);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (start && !busy) begin
        n_eff = (n_cfg < 3) ? 3 : (n_cfg > qbspe_pkg::MAX_POINTS_DEF) ?
                qbspe_pkg::MAX_POINTS_DEF : n_cfg;
        if (in_operation == qbspe_pkg::OP_EVAL) begin
          owed_q.insert(owed_q.size(), eval_curve(in_param_t));
        end else if (in_point_index < n_eff) begin
          ctrl_x[in_point_index] = in_point_x;
          ctrl_y[in_point_index] = in_point_y;
          ctrl_z[in_point_index] = in_point_z;
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == qbspe_pkg::REG_POINT_COUNT) n_cfg <= cfg_data;
        else if (cfg_index == qbspe_pkg::REG_BLEND_ENABLE) blend_cfg <= cfg_data[0];
      end
    end
  end

endmodule

// ----- tb/quadratic_bspline_point_eval_test.sv -----
`timescale 1ns / 1ps

module quadratic_bspline_point_eval_test;

  logic                             clk;
  logic                             rst_n;
  logic                             start;
  logic                             busy;
  logic                             in_operation;
  logic [qbspe_pkg::IDX_W-1:0]      in_point_index;
  logic [qbspe_pkg::IO_W-1:0]       in_point_x, in_point_y, in_point_z;
  logic [qbspe_pkg::T_W-1:0]        in_param_t;
  logic                             out_valid;
  logic [qbspe_pkg::IO_W-1:0]       out_curve_x, out_curve_y, out_curve_z;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [qbspe_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [qbspe_pkg::CFG_DATA_W-1:0] cfg_data;

  int mismatches, points_owed, points_checked;
  int beats_sent;
  int n_live;       // effective point count of the current phase
  bit gaps_on;      // random sender gaps, off for the final stretch

  quadratic_bspline_point_eval dut (.*);

  quadratic_bspline_point_eval_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous watchdog for a few thousand items
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // coordinates: mostly random, sometimes the extremes
  function automatic logic [qbspe_pkg::IO_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // parameter: edges, exact knots, saturating values, else uniform
  function automatic logic [qbspe_pkg::T_W-1:0] pick_t();
    int k;
    case ($urandom_range(0, 11))
      0: return '0;
      1: return qbspe_pkg::T_W'(qbspe_pkg::ONE_T);
      2: return qbspe_pkg::T_W'($urandom_range(qbspe_pkg::ONE_T + 1,
                                               (1 << qbspe_pkg::T_W) - 1));
      3: begin
        k = $urandom_range(0, n_live - 2);
        return qbspe_pkg::T_W'((k * qbspe_pkg::ONE_T) / (n_live - 2));
      end
      4: return qbspe_pkg::T_W'(qbspe_pkg::ONE_T - 1);
      default: return qbspe_pkg::T_W'($urandom_range(0, qbspe_pkg::ONE_T));
    endcase
  endfunction

  // one input beat; start stays high between back-to-back beats
  task automatic send_beat(logic op, logic [qbspe_pkg::IDX_W-1:0] idx,
                           logic [qbspe_pkg::T_W-1:0] t);
    bit taken;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start          <= 1'b1;
    in_operation   <= op;
    in_point_index <= idx;
    in_point_x     <= pick_coord();
    in_point_y     <= pick_coord();
    in_point_z     <= pick_coord();
    in_param_t     <= t;
    // busy is sampled mid-cycle, where it is settled for the coming edge
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    beats_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (points_owed != 0) @(posedge clk);
    repeat (12) @(posedge clk);   // pipeline is eight stages deep
  endtask

  task automatic write_reg(qbspe_pkg::cfg_reg_t idx, logic [qbspe_pkg::CFG_DATA_W-1:0] val);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // new settings, then load every point in use so no unwritten slot is read
  task automatic set_phase(int cnt, bit blend);
    drain();
    write_reg(qbspe_pkg::REG_POINT_COUNT, qbspe_pkg::CFG_DATA_W'(cnt));
    write_reg(qbspe_pkg::REG_BLEND_ENABLE, qbspe_pkg::CFG_DATA_W'(blend));
    n_live = (cnt < 3) ? 3 : (cnt > qbspe_pkg::MAX_POINTS_DEF) ? qbspe_pkg::MAX_POINTS_DEF
                                                                : cnt;
    for (int i = 0; i < n_live; i++)
      send_beat(qbspe_pkg::OP_WRITE, qbspe_pkg::IDX_W'(i), pick_t());
  endtask

  task automatic random_mix(int beats);
    for (int i = 0; i < beats; i++) begin
      if ($urandom_range(0, 9) < 7)
        send_beat(qbspe_pkg::OP_EVAL, qbspe_pkg::IDX_W'($urandom), pick_t());
      else if ($urandom_range(0, 4) == 0)   // may land beyond count
        send_beat(qbspe_pkg::OP_WRITE, qbspe_pkg::IDX_W'($urandom_range(0, 63)), pick_t());
      else
        send_beat(qbspe_pkg::OP_WRITE, qbspe_pkg::IDX_W'($urandom_range(0, n_live - 1)),
                  pick_t());
    end
  endtask

  initial begin
    int counts [10] = '{64, 0, 127, 5, 4, 2, 17, 64, 33, 3};
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_operation   <= qbspe_pkg::OP_WRITE;
    in_point_index <= '0;
    in_point_x     <= '0;
    in_point_y     <= '0;
    in_point_z     <= '0;
    in_param_t     <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= qbspe_pkg::REG_POINT_COUNT;
    cfg_data       <= '0;
    beats_sent = 0;
    gaps_on    = 1'b1;
    n_live     = 3;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, three points with random coordinates
    send_beat(qbspe_pkg::OP_WRITE, 6'd0, '0);
    send_beat(qbspe_pkg::OP_WRITE, 6'd1, qbspe_pkg::T_W'(qbspe_pkg::ONE_T));
    send_beat(qbspe_pkg::OP_WRITE, 6'd2, '1);
    send_beat(qbspe_pkg::OP_WRITE, 6'd63, '0);   // beyond count, dropped
    send_beat(qbspe_pkg::OP_WRITE, 6'd3, '0);    // beyond count, dropped
    send_beat(qbspe_pkg::OP_EVAL, '1, '0);
    send_beat(qbspe_pkg::OP_EVAL, '0, qbspe_pkg::T_W'(qbspe_pkg::ONE_T));
    send_beat(qbspe_pkg::OP_EVAL, '0, qbspe_pkg::T_W'(qbspe_pkg::ONE_T / 2));
    send_beat(qbspe_pkg::OP_EVAL, '0, '1);       // above one, saturates
    send_beat(qbspe_pkg::OP_EVAL, '0, qbspe_pkg::T_W'(qbspe_pkg::ONE_T + 1));
    send_beat(qbspe_pkg::OP_EVAL, '0, qbspe_pkg::T_W'(1));
    send_beat(qbspe_pkg::OP_EVAL, '0, qbspe_pkg::T_W'(qbspe_pkg::ONE_T - 1));

    // phases over the count range, blend toggled; the sender runs dry at each
    for (int p = 0; p < 10; p++) begin
      set_phase(counts[p], p[0]);
      if (p == 9) gaps_on = 1'b0;
      random_mix(158);
    end

    drain();
    $display("%0d input beats sent over ten settings (counts 0..127, blend on and off)",
             beats_sent);
    $display("%0d curve points checked", points_checked);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/qbspe_pkg.sv
hdl/quadratic_bspline_point_eval.sv
tb/quadratic_bspline_point_eval_checker.sv
tb/quadratic_bspline_point_eval_test.sv
